// File: src/oklab_to_srgb8_pixel_converter_defines.svh
// ----------------------------------------------------------------------------
// Oklab to sRGB8 converter: assertion macros
// Shorthand for clocked checks, reset masks them.
// ----------------------------------------------------------------------------
`ifndef OKLAB_TO_SRGB8_PIXEL_CONVERTER_DEFINES_SVH
`define OKLAB_TO_SRGB8_PIXEL_CONVERTER_DEFINES_SVH

// same-cycle implication
`define OKS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OKS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/oksrgb_pkg.sv
// ----------------------------------------------------------------------------
// oksrgb_pkg
// Widths, matrix coefficients and pipeline control types for the converter.
// ----------------------------------------------------------------------------
package oksrgb_pkg;

	localparam int FRAC_BITS_DEF       = 14;
	localparam int CURVE_ADDR_BITS_DEF = 10;

	localparam int IN_W        = 16;
	localparam int LMS_W       = 18;  // l', m', s' after the first matrix
	localparam int SQ_W        = 2 * LMS_W;
	localparam int CUBE_FULL_W = 3 * LMS_W;
	localparam int COEF_W      = 20;
	localparam int COEF_SH     = 16;
	localparam int LIN_FRAC    = 20;  // linear channels, 1.0 = 2^20
	localparam int ENC_W       = 17;  // encoded value, 1.0 = 65536
	localparam int ENC_SH      = 16;
	localparam int BYTE_W      = 8;

	localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'd255;

	// Oklab -> l'm's'
	localparam logic signed [COEF_W-1:0] M1_LA =  20'sd25974;
	localparam logic signed [COEF_W-1:0] M1_LB =  20'sd14143;
	localparam logic signed [COEF_W-1:0] M1_MA = -20'sd6918;
	localparam logic signed [COEF_W-1:0] M1_MB = -20'sd4185;
	localparam logic signed [COEF_W-1:0] M1_SA = -20'sd5864;
	localparam logic signed [COEF_W-1:0] M1_SB = -20'sd84639;

	// LMS -> linear sRGB
	localparam logic signed [COEF_W-1:0] M2_RL =  20'sd267173;
	localparam logic signed [COEF_W-1:0] M2_RM = -20'sd216774;
	localparam logic signed [COEF_W-1:0] M2_RS =  20'sd15137;
	localparam logic signed [COEF_W-1:0] M2_GL = -20'sd83128;
	localparam logic signed [COEF_W-1:0] M2_GM =  20'sd171033;
	localparam logic signed [COEF_W-1:0] M2_GS = -20'sd22369;
	localparam logic signed [COEF_W-1:0] M2_BL = -20'sd275;
	localparam logic signed [COEF_W-1:0] M2_BM = -20'sd46099;
	localparam logic signed [COEF_W-1:0] M2_BS =  20'sd111910;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} stage_en_t;

	function automatic int cube_w(int frac_bits);
		return CUBE_FULL_W - (3 * frac_bits - LIN_FRAC) + 1;
	endfunction

	function automatic int lin_w(int c_w);
		return c_w + COEF_W + 2 - COEF_SH;
	endfunction

endpackage

// File: src/oklab_to_srgb8_pixel_converter.sv
// ----------------------------------------------------------------------------
// oklab_to_srgb8_pixel_converter
// Oklab pixel in, 8-bit sRGB plus alpha and gamut flag out.
//
//   channel | signals                                    | flow control
//   --------+--------------------------------------------+---------------
//   input   | light, green_red, blue_yellow              | in_valid/in_stall
//   output  | red, green, blue, alpha, in_gamut          | out_valid/out_stall
//   config  | cfg_data (out_of_gamut_mode)               | cfg_valid/cfg_ready
//
// One pixel per clock while out_stall is low; the stages in order are: matrix,
// square, cube, products, sums, curve ROM read, interpolation. Each stage moves on
// when its successor is empty or moving, so bubbles close up under a stall;
// in_stall rises only when all seven stages hold a pixel and out_stall is high.
// Reset clears the valid bits and the mode (transparent); no table fill.
// ----------------------------------------------------------------------------
`include "oklab_to_srgb8_pixel_converter_defines.svh"

module oklab_to_srgb8_pixel_converter #(
	parameter int FRAC_BITS       = oksrgb_pkg::FRAC_BITS_DEF,
	parameter int CURVE_ADDR_BITS = oksrgb_pkg::CURVE_ADDR_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [oksrgb_pkg::IN_W-1:0]  light,
	input  logic signed [oksrgb_pkg::IN_W-1:0]  green_red,
	input  logic signed [oksrgb_pkg::IN_W-1:0]  blue_yellow,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [oksrgb_pkg::BYTE_W-1:0]       red,
	output logic [oksrgb_pkg::BYTE_W-1:0]       green,
	output logic [oksrgb_pkg::BYTE_W-1:0]       blue,
	output logic [oksrgb_pkg::BYTE_W-1:0]       alpha,
	output logic                                in_gamut,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_data
);
	import oksrgb_pkg::*;

	localparam int C_W   = cube_w(FRAC_BITS);
	localparam int LIN_W = lin_w(C_W);
	localparam logic [LIN_W-1:0] LIN_ONE = LIN_W'(1) << LIN_FRAC;

	stage_en_t en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic mode_q;
	logic ok_s6, ok_s7, blank_s7;

	logic signed [LMS_W-1:0] l_s1, m_s1, s_s1;
	logic signed [C_W-1:0]   cl_s3, cm_s3, cs_s3;
	logic signed [LIN_W-1:0] r_s5, g_s5, b_s5;
	logic [BYTE_W-1:0]       red_enc, green_enc, blue_enc;
	logic                    ok_lin;

	assign en.s7 = !v_s7 || !out_stall;
	assign en.s6 = !v_s6 || en.s7;
	assign en.s5 = !v_s5 || en.s6;
	assign en.s4 = !v_s4 || en.s5;
	assign en.s3 = !v_s3 || en.s4;
	assign en.s2 = !v_s2 || en.s3;
	assign en.s1 = !v_s1 || en.s2;

	assign in_stall  = !en.s1;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			v_s7   <= 1'b0;
			mode_q <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= in_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
			if (en.s6) v_s6 <= v_s5;
			if (en.s7) v_s7 <= v_s6;
			if (cfg_valid && cfg_ready) mode_q <= cfg_data;
		end
	end

	oksrgb_lms u_lms (
		.clk, .en, .light, .green_red, .blue_yellow, .l_s1, .m_s1, .s_s1
	);

	oksrgb_cube #(.FRAC_BITS(FRAC_BITS)) u_cube_l (.clk, .en, .x(l_s1), .c_s3(cl_s3));
	oksrgb_cube #(.FRAC_BITS(FRAC_BITS)) u_cube_m (.clk, .en, .x(m_s1), .c_s3(cm_s3));
	oksrgb_cube #(.FRAC_BITS(FRAC_BITS)) u_cube_s (.clk, .en, .x(s_s1), .c_s3(cs_s3));

	oksrgb_mat #(.C_W(C_W)) u_mat (
		.clk, .en, .cl(cl_s3), .cm(cm_s3), .cs(cs_s3), .r_s5, .g_s5, .b_s5
	);

	oksrgb_curve #(.CURVE_ADDR_BITS(CURVE_ADDR_BITS), .LIN_W(LIN_W)) u_curve_r (
		.clk, .en, .lin(r_s5), .enc_s7(red_enc)
	);
	oksrgb_curve #(.CURVE_ADDR_BITS(CURVE_ADDR_BITS), .LIN_W(LIN_W)) u_curve_g (
		.clk, .en, .lin(g_s5), .enc_s7(green_enc)
	);
	oksrgb_curve #(.CURVE_ADDR_BITS(CURVE_ADDR_BITS), .LIN_W(LIN_W)) u_curve_b (
		.clk, .en, .lin(b_s5), .enc_s7(blue_enc)
	);

	// gamut: every linear channel within 0..1
	assign ok_lin = !r_s5[LIN_W-1] && ($unsigned(r_s5) <= LIN_ONE)
		&& !g_s5[LIN_W-1] && ($unsigned(g_s5) <= LIN_ONE)
		&& !b_s5[LIN_W-1] && ($unsigned(b_s5) <= LIN_ONE);

	always_ff @(posedge clk) begin
		if (en.s6) ok_s6 <= ok_lin;
		if (en.s7) begin
			ok_s7    <= ok_s6;
			blank_s7 <= !ok_s6 && !mode_q;
		end
	end

	assign out_valid = v_s7;
	assign red       = blank_s7 ? '0 : red_enc;
	assign green     = blank_s7 ? '0 : green_enc;
	assign blue      = blank_s7 ? '0 : blue_enc;
	assign alpha     = blank_s7 ? '0 : ALPHA_OPAQUE;
	assign in_gamut  = ok_s7;

	`OKS_ASSERT_NOW(a_stall_only_full, in_stall, v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && v_s7 && out_stall, "input stalled with a free stage")
	`OKS_ASSERT_NEXT(a_s1_held, v_s1 && !en.s2, v_s1, "stage 1 request lost under stall")
	`OKS_ASSERT_NOW(a_transparent, out_valid && !in_gamut && !mode_q, red == '0 && green == '0 && blue == '0 && alpha == '0, "out-of-gamut pixel not blanked")
	`OKS_ASSERT_NOW(a_opaque, out_valid && in_gamut, alpha == ALPHA_OPAQUE, "in-gamut pixel not opaque")

endmodule

// File: src/oksrgb_lms.sv
// ----------------------------------------------------------------------------
// oksrgb_lms
// Stage 1: Oklab to non-linear cone values through the inverse matrix.
// ----------------------------------------------------------------------------
module oksrgb_lms (
	input  logic                                 clk,
	input  oksrgb_pkg::stage_en_t                en,
	input  logic signed [oksrgb_pkg::IN_W-1:0]   light,
	input  logic signed [oksrgb_pkg::IN_W-1:0]   green_red,
	input  logic signed [oksrgb_pkg::IN_W-1:0]   blue_yellow,
	output logic signed [oksrgb_pkg::LMS_W-1:0]  l_s1,
	output logic signed [oksrgb_pkg::LMS_W-1:0]  m_s1,
	output logic signed [oksrgb_pkg::LMS_W-1:0]  s_s1
);
	import oksrgb_pkg::*;

	localparam int ACC_W = 34;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (COEF_SH - 1);

	logic signed [ACC_W-1:0] lx, ax, bx, l_acc, m_acc, s_acc;

	assign lx = ACC_W'(light) <<< COEF_SH;
	assign ax = ACC_W'(green_red);
	assign bx = ACC_W'(blue_yellow);

	assign l_acc = lx + ax * ACC_W'(M1_LA) + bx * ACC_W'(M1_LB) + HALF;
	assign m_acc = lx + ax * ACC_W'(M1_MA) + bx * ACC_W'(M1_MB) + HALF;
	assign s_acc = lx + ax * ACC_W'(M1_SA) + bx * ACC_W'(M1_SB) + HALF;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			l_s1 <= LMS_W'(l_acc >>> COEF_SH);
			m_s1 <= LMS_W'(m_acc >>> COEF_SH);
			s_s1 <= LMS_W'(s_acc >>> COEF_SH);
		end
	end

endmodule

// File: src/oksrgb_cube.sv
// ----------------------------------------------------------------------------
// oksrgb_cube
// Stages 2-3: cube of one cone value, square then multiply, rounded to Q.20.
// ----------------------------------------------------------------------------
module oksrgb_cube #(
	parameter int FRAC_BITS = oksrgb_pkg::FRAC_BITS_DEF
) (
	input  logic                                           clk,
	input  oksrgb_pkg::stage_en_t                          en,
	input  logic signed [oksrgb_pkg::LMS_W-1:0]            x,
	output logic signed [oksrgb_pkg::cube_w(FRAC_BITS)-1:0] c_s3
);
	import oksrgb_pkg::*;

	localparam int C_W     = cube_w(FRAC_BITS);
	localparam int CUBE_SH = 3 * FRAC_BITS - LIN_FRAC;
	localparam logic signed [CUBE_FULL_W-1:0] HALF = CUBE_FULL_W'(1) <<< (CUBE_SH - 1);

	logic signed [SQ_W-1:0]        sq_s2;
	logic signed [LMS_W-1:0]       x_s2;
	logic signed [CUBE_FULL_W-1:0] full;

	assign full = CUBE_FULL_W'(sq_s2) * CUBE_FULL_W'(x_s2) + HALF;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			sq_s2 <= SQ_W'(x) * SQ_W'(x);
			x_s2  <= x;
		end
		if (en.s3) begin
			c_s3 <= C_W'(full >>> CUBE_SH);
		end
	end

endmodule

// File: src/oksrgb_mat.sv
// ----------------------------------------------------------------------------
// oksrgb_mat
// Stages 4-5: cone cubes to linear sRGB; products first, then sum and round.
// ----------------------------------------------------------------------------
module oksrgb_mat #(
	parameter int C_W = oksrgb_pkg::cube_w(oksrgb_pkg::FRAC_BITS_DEF)
) (
	input  logic                                    clk,
	input  oksrgb_pkg::stage_en_t                   en,
	input  logic signed [C_W-1:0]                   cl,
	input  logic signed [C_W-1:0]                   cm,
	input  logic signed [C_W-1:0]                   cs,
	output logic signed [oksrgb_pkg::lin_w(C_W)-1:0] r_s5,
	output logic signed [oksrgb_pkg::lin_w(C_W)-1:0] g_s5,
	output logic signed [oksrgb_pkg::lin_w(C_W)-1:0] b_s5
);
	import oksrgb_pkg::*;

	localparam int P_W   = C_W + COEF_W;
	localparam int SUM_W = P_W + 2;
	localparam int LIN_W = lin_w(C_W);
	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (COEF_SH - 1);

	logic signed [P_W-1:0] rl_s4, rm_s4, rs_s4, gl_s4, gm_s4, gs_s4, bl_s4, bm_s4, bs_s4;
	logic signed [SUM_W-1:0] r_sum, g_sum, b_sum;

	assign r_sum = SUM_W'(rl_s4) + SUM_W'(rm_s4) + SUM_W'(rs_s4) + HALF;
	assign g_sum = SUM_W'(gl_s4) + SUM_W'(gm_s4) + SUM_W'(gs_s4) + HALF;
	assign b_sum = SUM_W'(bl_s4) + SUM_W'(bm_s4) + SUM_W'(bs_s4) + HALF;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			rl_s4 <= P_W'(cl) * P_W'(M2_RL);
			rm_s4 <= P_W'(cm) * P_W'(M2_RM);
			rs_s4 <= P_W'(cs) * P_W'(M2_RS);
			gl_s4 <= P_W'(cl) * P_W'(M2_GL);
			gm_s4 <= P_W'(cm) * P_W'(M2_GM);
			gs_s4 <= P_W'(cs) * P_W'(M2_GS);
			bl_s4 <= P_W'(cl) * P_W'(M2_BL);
			bm_s4 <= P_W'(cm) * P_W'(M2_BM);
			bs_s4 <= P_W'(cs) * P_W'(M2_BS);
		end
		if (en.s5) begin
			r_s5 <= LIN_W'(r_sum >>> COEF_SH);
			g_s5 <= LIN_W'(g_sum >>> COEF_SH);
			b_s5 <= LIN_W'(b_sum >>> COEF_SH);
		end
	end

endmodule

// File: src/oksrgb_curve.sv
// ----------------------------------------------------------------------------
// oksrgb_curve
// Stages 6-7: sRGB transfer curve from an interpolated ROM, rounded to a byte.
// ----------------------------------------------------------------------------
module oksrgb_curve #(
	parameter int CURVE_ADDR_BITS = oksrgb_pkg::CURVE_ADDR_BITS_DEF,
	parameter int LIN_W           = 21
) (
	input  logic                                clk,
	input  oksrgb_pkg::stage_en_t               en,
	input  logic signed [LIN_W-1:0]             lin,
	output logic [oksrgb_pkg::BYTE_W-1:0]       enc_s7
);
	import oksrgb_pkg::*;

	localparam int SH   = LIN_FRAC - CURVE_ADDR_BITS;
	localparam int SIZE = (1 << CURVE_ADDR_BITS) + 1;
	localparam int AW   = CURVE_ADDR_BITS + 1;
	localparam int PW   = ENC_W + 2 + SH;
	localparam int BW_W = ENC_W + BYTE_W;
	localparam logic [AW-1:0] LAST = AW'(SIZE - 1);
	localparam logic [LIN_W-1:0] LIN_ONE = LIN_W'(1) << LIN_FRAC;
	localparam logic signed [PW-1:0] ENC_MAX = PW'(1) <<< ENC_SH;
	// divisor of the linear toe, 100 * table steps
	localparam logic [63:0] TOE_DEN = 64'd100 << CURVE_ADDR_BITS;

	typedef logic [ENC_W-1:0] curve_arr_t [SIZE];

	function automatic logic [63:0] mulq30(logic [63:0] p, logic [63:0] q);
		return (p * q) >> 30;
	endfunction

	function automatic logic [63:0] pow12(logic [63:0] w);
		logic [63:0] w2, w4, w8;
		w2 = mulq30(w, w);
		w4 = mulq30(w2, w2);
		w8 = mulq30(w4, w4);
		return mulq30(w8, w4);
	endfunction

	function automatic curve_arr_t build_curve();
		curve_arr_t  t;
		int          k;
		logic [63:0] i, x30, lo, hi, mid, w2, y;
		longint      enc30, enc16;
		for (k = 0; k < SIZE; k++) begin
			i   = 64'(k);
			x30 = i << (30 - CURVE_ADDR_BITS);
			if (i * 64'd10000000 <= (64'd31308 << CURVE_ADDR_BITS)) begin
				// linear toe of the curve
				t[k] = ENC_W'((i * 64'd1292 * 64'd65536 + (64'd50 << CURVE_ADDR_BITS))
					/ TOE_DEN);
			end else begin
				lo = 64'd0;
				hi = 64'd1 << 30;
				while (lo < hi) begin
					mid = (lo + hi + 64'd1) >> 1;
					if (pow12(mid) <= x30) lo = mid;
					else hi = mid - 64'd1;
				end
				w2    = mulq30(lo, lo);
				y     = mulq30(mulq30(w2, w2), lo);
				enc30 = (longint'(y * 64'd1055) - longint'(64'd55 << 30)) / 1000;
				if (enc30 < 0) enc30 = 0;
				enc16 = (enc30 + 8192) >>> 14;
				if (enc16 > 65536) enc16 = 65536;
				t[k] = ENC_W'(enc16);
			end
		end
		return t;
	endfunction

	localparam curve_arr_t CURVE = build_curve();

	logic [LIN_FRAC:0]    v;
	logic [AW-1:0]        idx, idx1;
	logic [ENC_W-1:0]     t0_s6, t1_s6;
	logic [SH-1:0]        frac_s6;
	logic signed [PW-1:0] diff, prod, e;
	logic [ENC_W-1:0]     ec;
	logic [BW_W-1:0]      bw;

	always_comb begin
		if (lin[LIN_W-1]) v = '0;
		else if ($unsigned(lin) > LIN_ONE) v = (LIN_FRAC + 1)'(LIN_ONE);
		else v = (LIN_FRAC + 1)'($unsigned(lin));
	end

	assign idx  = v[LIN_FRAC:SH];
	// the top entry has no right neighbour; its fraction is zero anyway
	assign idx1 = (idx == LAST) ? idx : idx + AW'(1);

	always_ff @(posedge clk) begin
		if (en.s6) begin
			t0_s6   <= CURVE[idx];
			t1_s6   <= CURVE[idx1];
			frac_s6 <= v[SH-1:0];
		end
	end

	assign diff = PW'($signed({1'b0, t1_s6})) - PW'($signed({1'b0, t0_s6}));
	assign prod = diff * PW'($signed({1'b0, frac_s6}));
	assign e    = PW'($signed({1'b0, t0_s6})) + (prod >>> SH);

	always_comb begin
		if (e < 0) ec = '0;
		else if (e > ENC_MAX) ec = ENC_W'(ENC_MAX);
		else ec = ENC_W'(e);
	end

	assign bw = BW_W'(ec) * BW_W'(255) + (BW_W'(1) << (ENC_SH - 1));

	always_ff @(posedge clk) begin
		if (en.s7) begin
			enc_s7 <= bw[ENC_SH +: BYTE_W];
		end
	end

endmodule
